[design/nsc_pkg.sv]
// Package for the sentence capture block: sizes, register indexes, state and result types.
package nsc_pkg;

  localparam int BUFFER_DEPTH    = 256;
  localparam int SEPARATOR_SLOTS = 32;

  localparam int IDX_W = $clog2(BUFFER_DEPTH + 1);
  localparam int SEP_W = $clog2(SEPARATOR_SLOTS + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_WORD  = 2'd0,
    CFG_START     = 2'd1,
    CFG_SEPARATOR = 2'd2,
    CFG_RSVD      = 2'd3
  } cfg_idx_t;

  localparam logic [23:0] TAG_RST   = 24'h474741;
  localparam logic [7:0]  START_RST = 8'h24;
  localparam logic [7:0]  SEP_RST   = 8'h2C;

  typedef struct packed {
    logic [23:0] tag_word;
    logic [7:0]  start_byte;
    logic [7:0]  separator_byte;
  } cfg_t;

  typedef struct packed {
    logic [23:0]      tag_window;
    logic             capture_flag;
    logic [IDX_W-1:0] write_index;
    logic [SEP_W-1:0] separator_count;
  } state_t;

  typedef struct packed {
    logic       char_write;
    logic [7:0] char_index;
    logic [7:0] char_value;
    logic       comma_write;
    logic [4:0] comma_slot;
    logic [7:0] comma_position;
    logic       sentence_start;
    logic       capturing;
    logic       overflow;
  } result_t;

endpackage

[design/nsc_step.sv]
// Per-item capture logic: next state and result for one received byte.
module nsc_step
  import nsc_pkg::*;
(
  input  cfg_t       cfg,
  input  state_t     cur,
  input  logic [7:0] rx_byte,
  output state_t     nxt,
  output result_t    res
);

  always_comb begin
    nxt = cur;
    res = '0;
    if (rx_byte == cfg.start_byte) begin
      nxt.write_index     = '0;
      nxt.separator_count = '0;
      nxt.capture_flag    = 1'b0;
      res.sentence_start  = 1'b1;
    end else if (cur.capture_flag) begin
      if (cur.write_index < IDX_W'(BUFFER_DEPTH)) begin
        if (rx_byte == cfg.separator_byte) begin
          if (cur.separator_count < SEP_W'(SEPARATOR_SLOTS)) begin
            res.comma_write     = 1'b1;
            res.comma_slot      = 5'(cur.separator_count);
            res.comma_position  = 8'(cur.write_index);
            nxt.separator_count = cur.separator_count + SEP_W'(1);
          end else begin
            res.overflow = 1'b1;
          end
        end
        res.char_write  = 1'b1;
        res.char_index  = 8'(cur.write_index);
        res.char_value  = rx_byte;
        nxt.write_index = cur.write_index + IDX_W'(1);
      end else begin
        res.overflow = 1'b1;
      end
    end else if (cur.tag_window == cfg.tag_word) begin
      nxt.capture_flag = 1'b1;
      nxt.tag_window   = '0;
    end else begin
      nxt.tag_window = {cur.tag_window[15:0], rx_byte};
    end
    res.capturing = nxt.capture_flag;
  end

endmodule

[design/nmea_sentence_capture_top.sv]
// Top level of the sentence capture block: config registers, state, output register.
// One received byte is taken per clock cycle while the output register is free or being
// emptied; each byte yields exactly one result, registered when it is accepted, from the
// single compare-and-increment step between the capture state registers and the output
// register, which frees as the downstream side takes its result. Config writes never stall.
module nmea_sentence_capture_top
  import nsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_char_write,
  output logic [7:0]            out_char_index,
  output logic [7:0]            out_char_value,
  output logic                  out_comma_write,
  output logic [4:0]            out_comma_slot,
  output logic [7:0]            out_comma_position,
  output logic                  out_sentence_start,
  output logic                  out_capturing,
  output logic                  out_overflow,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  state_t  st_r, st_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r;
  logic    in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  nsc_step u_step (
    .cfg     (cfg_r),
    .cur     (st_r),
    .rx_byte (in_rx_byte),
    .nxt     (st_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tag_word       <= TAG_RST;
      cfg_r.start_byte     <= START_RST;
      cfg_r.separator_byte <= SEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TAG_WORD:  cfg_r.tag_word       <= cfg_data;
        CFG_START:     cfg_r.start_byte     <= cfg_data[7:0];
        CFG_SEPARATOR: cfg_r.separator_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        st_r <= st_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_char_write     = res_r.char_write;
  assign out_char_index     = res_r.char_index;
  assign out_char_value     = res_r.char_value;
  assign out_comma_write    = res_r.comma_write;
  assign out_comma_slot     = res_r.comma_slot;
  assign out_comma_position = res_r.comma_position;
  assign out_sentence_start = res_r.sentence_start;
  assign out_capturing      = res_r.capturing;
  assign out_overflow       = res_r.overflow;

  a_acc_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted item produced no result");

  a_comma_with_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.comma_write) |->
      (res_r.char_write && res_r.comma_position == res_r.char_index))
    else $error("separator recorded without matching buffer write");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.sentence_start) |->
      (!res_r.capturing && !res_r.char_write && !res_r.overflow))
    else $error("start byte result carries a write or capture");

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.write_index <= IDX_W'(BUFFER_DEPTH)) &&
    (st_r.separator_count <= SEP_W'(SEPARATOR_SLOTS)))
    else $error("capture index or separator count past its depth");

endmodule
